[src/vpid_pkg.sv]
// ----------------------------------------------------------------------------
// vpid_pkg
// Shared types and constants of the velocity PID controller: register map,
// configuration bundle, result bundle and fixed-point format.
// ----------------------------------------------------------------------------
package vpid_pkg;

  // Fixed-point format of all fractional quantities (Qx.FRACTION_BITS)
  localparam int unsigned FRACTION_BITS = 16;

  // Output clamp and width
  localparam int unsigned DRIVE_LIMIT = 127;
  localparam int unsigned DRIVE_W     = 8;
  localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = DRIVE_W'(DRIVE_LIMIT);
  localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = -DRIVE_W'(DRIVE_LIMIT);

  // Register file geometry
  localparam int unsigned CFG_W  = 32;
  localparam int unsigned ZONE_W = 31;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned IVL_W  = 16;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_SETPOINT = 3'd0;
  localparam logic [IDX_W-1:0] REG_GAIN_P   = 3'd1;
  localparam logic [IDX_W-1:0] REG_GAIN_I   = 3'd2;
  localparam logic [IDX_W-1:0] REG_GAIN_D   = 3'd3;
  localparam logic [IDX_W-1:0] REG_GAIN_FF  = 3'd4;
  localparam logic [IDX_W-1:0] REG_ZONE     = 3'd5;
  localparam logic [IDX_W-1:0] REG_INVERT   = 3'd6;

  // Register reset values
  localparam logic signed [CFG_W-1:0] GAIN_P_RST  = 32'sd22938;
  localparam logic signed [CFG_W-1:0] GAIN_FF_RST = -32'sd66;
  localparam logic [ZONE_W-1:0]       ZONE_RST    = 31'd134217728;

  // Configuration bundle seen by the datapath
  typedef struct packed {
    logic signed [CFG_W-1:0] setpoint;
    logic signed [CFG_W-1:0] gain_p;
    logic signed [CFG_W-1:0] gain_i;
    logic signed [CFG_W-1:0] gain_d;
    logic signed [CFG_W-1:0] gain_ff;
    logic [ZONE_W-1:0]       integral_zone;
    logic                    invert_sample;
  } cfg_t;

  // Finished result handed from the sequencer to the output register
  typedef struct packed {
    logic                      valid;
    logic signed [DRIVE_W-1:0] drive;
  } res_t;

endpackage

[src/vpid_regs.sv]
// ----------------------------------------------------------------------------
// vpid_regs
// Configuration register file: write-only, one register per index; writes
// to unused indexes are dropped.
// ----------------------------------------------------------------------------
module vpid_regs import vpid_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  output cfg_t             cfg_o
);

  cfg_t cfg_q;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.setpoint      <= '0;
      cfg_q.gain_p        <= GAIN_P_RST;
      cfg_q.gain_i        <= '0;
      cfg_q.gain_d        <= '0;
      cfg_q.gain_ff       <= GAIN_FF_RST;
      cfg_q.integral_zone <= ZONE_RST;
      cfg_q.invert_sample <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SETPOINT: cfg_q.setpoint      <= cfg_wdata_i;
        REG_GAIN_P:   cfg_q.gain_p        <= cfg_wdata_i;
        REG_GAIN_I:   cfg_q.gain_i        <= cfg_wdata_i;
        REG_GAIN_D:   cfg_q.gain_d        <= cfg_wdata_i;
        REG_GAIN_FF:  cfg_q.gain_ff       <= cfg_wdata_i;
        REG_ZONE:     cfg_q.integral_zone <= cfg_wdata_i[ZONE_W-1:0];
        REG_INVERT:   cfg_q.invert_sample <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[src/vpid_div.sv]
// ----------------------------------------------------------------------------
// vpid_div
// Shared unsigned restoring divider, DIV_STEP quotient bits per cycle.
// Quotient is valid from the done pulse until the next start.
// ----------------------------------------------------------------------------
module vpid_div import vpid_pkg::*; #(
  parameter int unsigned DIV_W     = 64,
  parameter int unsigned DIV_STEP  = 4,
  parameter int unsigned DIVISOR_W = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DIV_W-1:0]     dividend_i,
  input  logic [DIVISOR_W-1:0] divisor_i,
  output logic                 done_o,
  output logic [DIV_W-1:0]     quotient_o
);

  localparam int unsigned STEPS = DIV_W / DIV_STEP;
  localparam int unsigned CNT_W = $clog2(STEPS + 1);

  logic [DIV_W-1:0]     work_q, work_d;
  logic [DIVISOR_W-1:0] rem_q, rem_d;
  logic [DIVISOR_W-1:0] dvs_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 done_q;
  logic [DIVISOR_W:0]   trial;

  // DIV_STEP shift/compare/subtract steps; dividend shifts out the top,
  // quotient bits shift in at the bottom
  always_comb begin
    work_d = work_q;
    rem_d  = rem_q;
    trial  = '0;
    for (int k = 0; k < DIV_STEP; k++) begin
      trial  = {rem_d, work_d[DIV_W-1]};
      work_d = {work_d[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        rem_d     = DIVISOR_W'(trial - {1'b0, dvs_q});
        work_d[0] = 1'b1;
      end else begin
        rem_d = trial[DIVISOR_W-1:0];
      end
    end
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CNT_W'(1)) && !start_i;
      if (start_i) begin
        cnt_q <= CNT_W'(STEPS);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      work_q <= dividend_i;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
    end else if (cnt_q != '0) begin
      work_q <= work_d;
      rem_q  <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = work_q;

endmodule

[src/vpid_core.sv]
// ----------------------------------------------------------------------------
// vpid_core
// Sequencer of the controller: one 32x32 multiplier used in two passes per
// product, one shared divider, and the loop state (previous sample, integral,
// previous error).
// ----------------------------------------------------------------------------
module vpid_core import vpid_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cfg_t                          cfg_i,
  input  logic                          in_valid_i,
  input  logic signed [SAMPLE_BITS-1:0] encoder_count_i,
  input  logic [IVL_W-1:0]              interval_ms_i,
  output logic                          in_stall_o,
  input  logic                          res_ready_i,
  output res_t                          res_o
);

  // Widths
  localparam int unsigned MUL_W     = 32;
  localparam int unsigned OPA_W     = 2 * MUL_W;
  localparam int unsigned ACC_W     = 48;
  localparam int unsigned DE_W      = ACC_W + 1;
  localparam int unsigned TOT_W     = ACC_W + 2;
  localparam int unsigned SUM_W     = 56;
  localparam int unsigned DIFF_W    = SAMPLE_BITS + 1;
  localparam int unsigned MS_PER_S  = 1000;
  localparam int unsigned DIV_STEP  = 4;
  localparam int unsigned VEL_W     = SAMPLE_BITS + $clog2(MS_PER_S) + FRACTION_BITS + 1;
  localparam int unsigned DIV_RAW   = (VEL_W > OPA_W) ? VEL_W : OPA_W;
  localparam int unsigned DIV_W     = ((DIV_RAW + DIV_STEP - 1) / DIV_STEP) * DIV_STEP;
  localparam int unsigned HI_SHIFT  = MUL_W - FRACTION_BITS;
  localparam int unsigned HI_LIMB   = ACC_W - 1 - MUL_W + FRACTION_BITS;

  localparam logic [IVL_W-1:0]        MS_CONST = IVL_W'(MS_PER_S);
  localparam logic signed [ACC_W-1:0] ACC_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN  = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [OPA_W-1:0]        POS_LIM  = OPA_W'(ACC_MAX);
  localparam logic [OPA_W-1:0]        NEG_LIM  = POS_LIM + OPA_W'(1);
  localparam logic [OPA_W-1:0]        HI_LIM   = OPA_W'(1) << HI_LIMB;

  // Sequencer states
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_LOAD     = 3'd1;
  localparam logic [2:0] S_MUL_LO   = 3'd2;
  localparam logic [2:0] S_MUL_HI   = 3'd3;
  localparam logic [2:0] S_POST_MUL = 3'd4;
  localparam logic [2:0] S_DIV_WAIT = 3'd5;
  localparam logic [2:0] S_POST_DIV = 3'd6;
  localparam logic [2:0] S_DRIVE    = 3'd7;

  // Computation phases
  localparam logic [2:0] PH_VEL = 3'd0;
  localparam logic [2:0] PH_INT = 3'd1;
  localparam logic [2:0] PH_DER = 3'd2;
  localparam logic [2:0] PH_TP  = 3'd3;
  localparam logic [2:0] PH_TI  = 3'd4;
  localparam logic [2:0] PH_TD  = 3'd5;
  localparam logic [2:0] PH_TF  = 3'd6;

  function automatic logic [ACC_W-1:0] abs_acc(input logic signed [ACC_W-1:0] x);
    return x[ACC_W-1] ? ACC_W'(-x) : ACC_W'(x);
  endfunction

  function automatic logic [CFG_W-1:0] abs_cfg(input logic signed [CFG_W-1:0] x);
    return x[CFG_W-1] ? CFG_W'(-x) : CFG_W'(x);
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [DE_W-1:0] x);
    logic signed [DE_W-1:0] hi;
    logic signed [DE_W-1:0] lo;
    hi = {ACC_MAX[ACC_W-1], ACC_MAX};
    lo = {ACC_MIN[ACC_W-1], ACC_MIN};
    if (x > hi) return ACC_MAX;
    if (x < lo) return ACC_MIN;
    return x[ACC_W-1:0];
  endfunction

  // State
  logic [2:0]                    state_q, state_d;
  logic [2:0]                    phase_q, phase_d;
  logic [OPA_W-1:0]              op_a_q, op_a_d;
  logic [MUL_W-1:0]              op_b_q, op_b_d;
  logic                          neg_q, neg_d;
  logic [OPA_W-1:0]              prod_lo_q, prod_lo_d;
  logic [OPA_W-1:0]              prod_hi_q, prod_hi_d;
  logic [IVL_W-1:0]              iv_q, iv_d;
  logic signed [SAMPLE_BITS-1:0] prev_count_q, prev_count_d;
  logic signed [ACC_W-1:0]       err_q, err_d;
  logic signed [ACC_W-1:0]       prev_err_q, prev_err_d;
  logic signed [ACC_W-1:0]       integral_q, integral_d;
  logic signed [ACC_W-1:0]       derr_q, derr_d;
  logic signed [TOT_W-1:0]       total_q, total_d;

  // Shared multiplier and divider hookup
  logic [MUL_W-1:0]  mul_src;
  logic [OPA_W-1:0]  mul_res;
  logic [OPA_W-1:0]  prod_full;
  logic              div_start;
  logic [DIV_W-1:0]  div_dividend;
  logic [IVL_W-1:0]  div_divisor;
  logic              div_done;
  logic [DIV_W-1:0]  quot;

  // Scratch values of the combinational step
  logic signed [SAMPLE_BITS-1:0] smax, smin, val;
  logic signed [DIFF_W-1:0]      dcount;
  logic [DIFF_W-1:0]             dmag;
  logic signed [DE_W-1:0]        de;
  logic [DE_W-1:0]               de_mag;
  logic [ACC_W-1:0]              vm;
  logic signed [ACC_W-1:0]       vel;
  logic [SUM_W-2:0]              inc_mag;
  logic signed [SUM_W-1:0]       inc, isum, zone_s;
  logic [OPA_W-1:0]              r_raw, r_mag;
  logic signed [ACC_W-1:0]       term;
  logic                          tot_neg;
  logic [TOT_W-1:0]              tot_mag, tot_int;
  logic [DRIVE_W-1:0]            drv_mag;

  // One 32x32 multiplier, low half of operand A first, then high half
  assign mul_src   = (state_q == S_MUL_HI) ? op_a_q[OPA_W-1:MUL_W] : op_a_q[MUL_W-1:0];
  assign mul_res   = mul_src * op_b_q;
  assign prod_full = prod_lo_q + (prod_hi_q << MUL_W);

  vpid_div #(
    .DIV_W     (DIV_W),
    .DIV_STEP  (DIV_STEP),
    .DIVISOR_W (IVL_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  // Sample conditioning: optional negate, saturating the most negative code
  assign smax   = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  assign smin   = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  assign val    = !cfg_i.invert_sample ? encoder_count_i :
                  (encoder_count_i == smin) ? smax : -encoder_count_i;
  assign dcount = {val[SAMPLE_BITS-1], val} - {prev_count_q[SAMPLE_BITS-1], prev_count_q};
  assign dmag   = dcount[DIFF_W-1] ? DIFF_W'(-dcount) : DIFF_W'(dcount);

  // Error change for the derivative
  assign de     = {err_q[ACC_W-1], err_q} - {prev_err_q[ACC_W-1], prev_err_q};
  assign de_mag = de[DE_W-1] ? DE_W'(-de) : DE_W'(de);

  // Velocity from the quotient, saturated to the accumulator range
  assign vm  = (quot > DIV_W'(POS_LIM)) ? ACC_W'(POS_LIM) : quot[ACC_W-1:0];
  assign vel = neg_q ? -$signed(vm) : $signed(vm);

  // Integral update
  assign inc_mag = quot[SUM_W-2:0];
  assign inc     = err_q[ACC_W-1] ? -$signed({1'b0, inc_mag}) : $signed({1'b0, inc_mag});
  assign isum    = {{(SUM_W-ACC_W){integral_q[ACC_W-1]}}, integral_q} + inc;
  assign zone_s  = $signed({{(SUM_W-ZONE_W){1'b0}}, cfg_i.integral_zone});

  // Q-format product rescale with saturation
  always_comb begin
    r_raw = (prod_hi_q << HI_SHIFT) + (prod_lo_q >> FRACTION_BITS);
    r_mag = (prod_hi_q >= HI_LIM) ? NEG_LIM : r_raw;
    if (!neg_q && r_mag > POS_LIM) begin
      r_mag = POS_LIM;
    end
    if (neg_q && r_mag > NEG_LIM) begin
      r_mag = NEG_LIM;
    end
    term = neg_q ? -$signed(r_mag[ACC_W-1:0]) : $signed(r_mag[ACC_W-1:0]);
  end

  // Final truncation toward zero and clamp
  assign tot_neg = total_q[TOT_W-1];
  assign tot_mag = tot_neg ? TOT_W'(-total_q) : TOT_W'(total_q);
  assign tot_int = tot_mag >> FRACTION_BITS;
  assign drv_mag = (tot_int > TOT_W'(DRIVE_LIMIT)) ? DRIVE_W'(DRIVE_LIMIT)
                                                   : tot_int[DRIVE_W-1:0];

  assign in_stall_o = (state_q != S_IDLE);

  // Sequencer
  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    op_a_d       = op_a_q;
    op_b_d       = op_b_q;
    neg_d        = neg_q;
    prod_lo_d    = prod_lo_q;
    prod_hi_d    = prod_hi_q;
    iv_d         = iv_q;
    prev_count_d = prev_count_q;
    err_d        = err_q;
    prev_err_d   = prev_err_q;
    integral_d   = integral_q;
    derr_d       = derr_q;
    total_d      = total_q;
    div_start    = 1'b0;
    div_dividend = DIV_W'(prod_full);
    div_divisor  = iv_q;
    res_o.valid  = 1'b0;
    res_o.drive  = tot_neg ? -$signed(drv_mag) : $signed(drv_mag);

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          iv_d         = (interval_ms_i == '0) ? IVL_W'(1) : interval_ms_i;
          prev_count_d = val;
          op_a_d       = OPA_W'(dmag);
          op_b_d       = MUL_W'(MS_CONST);
          neg_d        = dcount[DIFF_W-1];
          total_d      = '0;
          phase_d      = PH_VEL;
          state_d      = S_MUL_LO;
        end
      end

      // Operand setup for the next product
      S_LOAD: begin
        state_d = S_MUL_LO;
        unique case (phase_q)
          PH_INT: begin
            op_a_d = OPA_W'(abs_acc(err_q));
            op_b_d = MUL_W'(iv_q);
          end
          PH_DER: begin
            op_a_d     = OPA_W'(de_mag);
            op_b_d     = MUL_W'(MS_CONST);
            neg_d      = de[DE_W-1];
            prev_err_d = err_q;
          end
          PH_TP: begin
            op_a_d = OPA_W'(abs_acc(err_q));
            op_b_d = abs_cfg(cfg_i.gain_p);
            neg_d  = err_q[ACC_W-1] ^ cfg_i.gain_p[CFG_W-1];
          end
          PH_TI: begin
            op_a_d = OPA_W'(abs_acc(integral_q));
            op_b_d = abs_cfg(cfg_i.gain_i);
            neg_d  = integral_q[ACC_W-1] ^ cfg_i.gain_i[CFG_W-1];
          end
          PH_TD: begin
            op_a_d = OPA_W'(abs_acc(derr_q));
            op_b_d = abs_cfg(cfg_i.gain_d);
            neg_d  = derr_q[ACC_W-1] ^ cfg_i.gain_d[CFG_W-1];
          end
          default: begin
            op_a_d = OPA_W'(abs_cfg(cfg_i.setpoint));
            op_b_d = abs_cfg(cfg_i.gain_ff);
            neg_d  = cfg_i.setpoint[CFG_W-1] ^ cfg_i.gain_ff[CFG_W-1];
          end
        endcase
      end

      S_MUL_LO: begin
        prod_lo_d = mul_res;
        state_d   = S_MUL_HI;
      end

      S_MUL_HI: begin
        prod_hi_d = mul_res;
        state_d   = S_POST_MUL;
      end

      // Divisions start here; gain terms accumulate here
      S_POST_MUL: begin
        unique case (phase_q)
          PH_VEL: begin
            div_start    = 1'b1;
            div_dividend = DIV_W'(prod_full) << FRACTION_BITS;
            state_d      = S_DIV_WAIT;
          end
          PH_INT: begin
            div_start   = 1'b1;
            div_divisor = MS_CONST;
            state_d     = S_DIV_WAIT;
          end
          PH_DER: begin
            div_start = 1'b1;
            state_d   = S_DIV_WAIT;
          end
          PH_TP: begin
            total_d = total_q + TOT_W'(term);
            phase_d = PH_TI;
            state_d = S_LOAD;
          end
          PH_TI: begin
            total_d = total_q + TOT_W'(term);
            phase_d = PH_TD;
            state_d = S_LOAD;
          end
          PH_TD: begin
            total_d = total_q + TOT_W'(term);
            phase_d = PH_TF;
            state_d = S_LOAD;
          end
          default: begin
            total_d = total_q + TOT_W'(term);
            state_d = S_DRIVE;
          end
        endcase
      end

      S_DIV_WAIT: begin
        if (div_done) begin
          state_d = S_POST_DIV;
        end
      end

      S_POST_DIV: begin
        state_d = S_LOAD;
        unique case (phase_q)
          PH_VEL: begin
            err_d   = sat_acc({cfg_i.setpoint[CFG_W-1],
                               {(ACC_W-CFG_W){cfg_i.setpoint[CFG_W-1]}}, cfg_i.setpoint}
                              - {vel[ACC_W-1], vel});
            phase_d = PH_INT;
          end
          PH_INT: begin
            // Leaving the integral zone clears the accumulator
            if (isum > zone_s || isum < -zone_s) begin
              integral_d = '0;
            end else begin
              integral_d = isum[ACC_W-1:0];
            end
            phase_d = PH_DER;
          end
          default: begin
            if (neg_q) begin
              derr_d = (quot > DIV_W'(NEG_LIM)) ? ACC_MIN : -$signed(quot[ACC_W-1:0]);
            end else begin
              derr_d = (quot > DIV_W'(POS_LIM)) ? ACC_MAX : $signed(quot[ACC_W-1:0]);
            end
            phase_d = PH_TP;
          end
        endcase
      end

      default: begin
        if (res_ready_i) begin
          res_o.valid = 1'b1;
          state_d     = S_IDLE;
        end
      end
    endcase
  end

  // Control and loop state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      phase_q      <= PH_VEL;
      prev_count_q <= '0;
      prev_err_q   <= '0;
      integral_q   <= '0;
    end else begin
      state_q      <= state_d;
      phase_q      <= phase_d;
      prev_count_q <= prev_count_d;
      prev_err_q   <= prev_err_d;
      integral_q   <= integral_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    op_a_q    <= op_a_d;
    op_b_q    <= op_b_d;
    neg_q     <= neg_d;
    prod_lo_q <= prod_lo_d;
    prod_hi_q <= prod_hi_d;
    iv_q      <= iv_d;
    err_q     <= err_d;
    derr_q    <= derr_d;
    total_q   <= total_d;
  end

endmodule

[src/velocity_pid_controller.sv]
// ----------------------------------------------------------------------------
// velocity_pid_controller
// Velocity PID controller with setpoint feedforward for one wheel.
// ----------------------------------------------------------------------------
// Each transaction on the input channel is processed alone: the input stalls
// from acceptance until the sequencer has handed the motor command to the
// output register. Its length comes from the shared divider, which retires
// four quotient bits a cycle and runs three 64-bit divisions per update
// (velocity, integral step, derivative), plus two passes of the shared 32x32
// multiplier for each of the seven products. A finished command waits in the
// output register, so a new sample is taken while the previous command is
// still stalled downstream.
// Configuration registers may be written at any time the block is idle.
module velocity_pid_controller import vpid_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [IDX_W-1:0]              cfg_index_i,
  input  logic [CFG_W-1:0]              cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] encoder_count_i,
  input  logic [IVL_W-1:0]              interval_ms_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [DRIVE_W-1:0]     motor_drive_o
);

  cfg_t                      cfg;
  res_t                      res;
  logic                      res_ready;
  logic                      out_valid_q;
  logic signed [DRIVE_W-1:0] drive_q;

  vpid_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  vpid_core #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .in_valid_i      (in_valid_i),
    .encoder_count_i (encoder_count_i),
    .interval_ms_i   (interval_ms_i),
    .in_stall_o      (in_stall_o),
    .res_ready_i     (res_ready),
    .res_o           (res)
  );

  // Output register: free when empty or being taken this cycle
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      drive_q <= res.drive;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign motor_drive_o = drive_q;

endmodule

[src/vpid_checker.sv]
// ----------------------------------------------------------------------------
// vpid_checker
// Port-level checks of the velocity PID controller, bound to the top level.
// ----------------------------------------------------------------------------
module vpid_checker import vpid_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic signed [DRIVE_W-1:0] motor_drive_o
);

  // A stalled command stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(motor_drive_o))
    else $error("stalled motor command changed or dropped");

  // Commands stay inside the clamp
  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (motor_drive_o <= DRIVE_MAX && motor_drive_o >= DRIVE_MIN))
    else $error("motor command outside clamp");

  // One sample at a time: busy right after a transaction
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after a transaction");

  // A new command only comes out of a busy sequencer
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("command appeared without an update in progress");

endmodule

bind velocity_pid_controller vpid_checker u_vpid_checker (.*);

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the velocity PID controller. A behavioral predictor
// tracks the controller state and register settings and works out the motor
// command of every accepted sample transaction; each command that leaves the
// block is compared with the oldest prediction. Directed cases cover field and
// register extremes, then random tuning sets and smooth or noisy trajectories
// run under several idling and backpressure patterns.
// ----------------------------------------------------------------------------
module testbench;
  import vpid_pkg::*;

  localparam int SAMPLE_W       = 16;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 200;
  localparam int PRINT_LIMIT    = 200;

  // Register index that maps to nothing
  localparam logic [IDX_W-1:0] REG_UNMAPPED = 3'd7;

  // Random tuning styles
  localparam int TUNE_GENTLE = 0;
  localparam int TUNE_TIGHT  = 1;
  localparam int TUNE_WILD   = 2;

  // Idling patterns
  localparam int IDLE_NONE     = 0;
  localparam int IDLE_SENDER   = 1;
  localparam int IDLE_RECEIVER = 2;
  localparam int IDLE_BOTH     = 3;

  // 48-bit saturation bounds and time base
  localparam longint SAT_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SAT_LO = -SAT_HI - 1;
  localparam longint MS_PER_S = 1000;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [IDX_W-1:0]              cfg_index_i;
  logic [CFG_W-1:0]              cfg_wdata_i;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic signed [SAMPLE_W-1:0]    encoder_count_i;
  logic [IVL_W-1:0]              interval_ms_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic signed [DRIVE_W-1:0]     motor_drive_o;

  velocity_pid_controller #(.SAMPLE_BITS(SAMPLE_W)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .encoder_count_i (encoder_count_i),
    .interval_ms_i   (interval_ms_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .motor_drive_o   (motor_drive_o)
  );

  // Predicted commands still owed by the block, oldest first
  logic signed [DRIVE_W-1:0] pending_drive[$];

  int          mismatches;
  int          quiet_cycles;
  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  int          hold_off_left;
  logic signed [SAMPLE_W-1:0] last_count;

  // Mirror of the controller registers
  longint mir_setpoint, mir_gain_p, mir_gain_i, mir_gain_d, mir_gain_ff, mir_zone;
  bit     mir_invert;

  // Mirror of the controller state
  longint st_count, st_integral, st_error;

  // --------------------------------------------------------------------------
  // Fixed-point helpers
  // --------------------------------------------------------------------------
  function automatic longint unsigned magnitude(longint a);
    return (a < 0) ? $unsigned(-a) : $unsigned(a);
  endfunction

  function automatic longint with_sign(longint unsigned m, bit neg);
    return neg ? -$signed(m) : $signed(m);
  endfunction

  function automatic longint sat48(longint a);
    if (a > SAT_HI) return SAT_HI;
    if (a < SAT_LO) return SAT_LO;
    return a;
  endfunction

  function automatic longint div_toward_zero(longint n, longint unsigned d);
    return with_sign(magnitude(n) / d, n < 0);
  endfunction

  // Q-format product, truncated toward zero and saturated to 48 bits
  function automatic longint scale_q(longint a, longint b);
    longint unsigned ua, ub, hi, lo, r;
    bit neg;
    ua = magnitude(a);
    ub = magnitude(b);
    hi = (ua >> 32) * ub;
    lo = (ua & 64'hFFFF_FFFF) * ub;
    if (hi >= (64'd1 << (15 + FRACTION_BITS)))
      r = SAT_HI + 1;
    else
      r = (hi << (32 - FRACTION_BITS)) + (lo >> FRACTION_BITS);
    neg = (a < 0) != (b < 0);
    if (!neg && r > SAT_HI) r = SAT_HI;
    if (neg && r > SAT_HI + 1) r = SAT_HI + 1;
    return with_sign(r, neg);
  endfunction

  // --------------------------------------------------------------------------
  // Controller predictor
  // --------------------------------------------------------------------------
  function automatic void reset_prediction();
    // register reset values of the controller
    mir_setpoint = 0;
    mir_gain_p   = 22938;
    mir_gain_i   = 0;
    mir_gain_d   = 0;
    mir_gain_ff  = -66;
    mir_zone     = 134217728;
    mir_invert   = 1'b0;
    st_count     = 0;
    st_integral  = 0;
    st_error     = 0;
  endfunction

  function automatic void mirror_register(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    case (idx)
      REG_SETPOINT: mir_setpoint = $signed(data);
      REG_GAIN_P:   mir_gain_p   = $signed(data);
      REG_GAIN_I:   mir_gain_i   = $signed(data);
      REG_GAIN_D:   mir_gain_d   = $signed(data);
      REG_GAIN_FF:  mir_gain_ff  = $signed(data);
      REG_ZONE:     mir_zone     = data[ZONE_W-1:0];
      REG_INVERT:   mir_invert   = data[0];
      default:      ;
    endcase
  endfunction

  function automatic logic signed [DRIVE_W-1:0] predict_drive(
    logic signed [SAMPLE_W-1:0] count, logic [IVL_W-1:0] ivl_raw);
    longint sample, q, vel, err, inc, sum, derr, total, drive;
    longint unsigned ivl, uq, quot, rem, vmag;
    ivl = (ivl_raw == 0) ? 1 : ivl_raw;
    sample = count;
    // negation saturates the most negative sample
    if (mir_invert) begin
      sample = -sample;
      if (sample > (2 ** (SAMPLE_W - 1)) - 1) sample = (2 ** (SAMPLE_W - 1)) - 1;
    end

    // velocity in counts per second, Q format
    q = (sample - st_count) * MS_PER_S;
    uq = magnitude(q);
    quot = uq / ivl;
    rem = uq % ivl;
    if (quot >= (64'd1 << (47 - FRACTION_BITS)))
      vmag = SAT_HI;
    else
      vmag = (quot << FRACTION_BITS) + ((rem << FRACTION_BITS) / ivl);
    vel = with_sign(vmag, q < 0);
    st_count = sample;

    err = sat48(mir_setpoint - vel);

    // integral step, cleared outside the zone
    inc = with_sign(magnitude(err) * ivl / MS_PER_S, err < 0);
    sum = st_integral + inc;
    if (sum > mir_zone || sum < -mir_zone) sum = 0;
    st_integral = sum;

    derr = sat48(div_toward_zero((err - st_error) * MS_PER_S, ivl));
    st_error = err;

    total = scale_q(err, mir_gain_p) + scale_q(st_integral, mir_gain_i)
          + scale_q(derr, mir_gain_d) + scale_q(mir_setpoint, mir_gain_ff);
    drive = with_sign(magnitude(total) >> FRACTION_BITS, total < 0);
    if (drive > longint'(DRIVE_LIMIT)) drive = longint'(DRIVE_LIMIT);
    if (drive < -longint'(DRIVE_LIMIT)) drive = -longint'(DRIVE_LIMIT);
    return drive[DRIVE_W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus long hold-offs counted here
  // --------------------------------------------------------------------------
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_left > 0) begin
        out_stall_i <= 1'b1;
        hold_off_left--;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < rx_stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Mismatch reporting
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_LIMIT) $display("mismatch @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // Result checker: each accepted command against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_drive
    logic signed [DRIVE_W-1:0] due;
    if (out_valid_o && !out_stall_i) begin
      if (pending_drive.size() == 0) begin
        report_mismatch($sformatf("unexpected motor_drive %0d", motor_drive_o));
      end else begin
        due = pending_drive.pop_front();
        if (motor_drive_o !== due)
          report_mismatch($sformatf("motor_drive %0d, predicted %0d", motor_drive_o, due));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: cycles without any transaction on either channel
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", quiet_cycles);
      $display("testbench: errors");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  function automatic int rand_between(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] count,
                             input logic [IVL_W-1:0] ivl);
    int gap;
    gap = 0;
    while (gap < 16 && $urandom_range(0, 99) < tx_idle_pct) gap++;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    encoder_count_i <= count;
    interval_ms_i   <= ivl;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_drive.push_back(predict_drive(count, ivl));
    last_count = count;
  endtask

  // Stop offering and wait until every predicted command has come out
  task automatic wait_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_drive.size() != 0) @(posedge clk_i);
  endtask

  // Register writes happen only with the block idle
  task automatic write_register(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    wait_results();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    mirror_register(idx, data);
  endtask

  task automatic set_idling(input int mode);
    tx_idle_pct  = (mode == IDLE_SENDER) ? 50 : (mode == IDLE_BOTH) ? 7 : 0;
    rx_stall_pct = (mode == IDLE_RECEIVER) ? 50 : (mode == IDLE_BOTH) ? 7 : 0;
  endtask

  // New random tuning; all seven registers are rewritten
  task automatic retune(input int style);
    logic [CFG_W-1:0] zone;
    if (style == TUNE_WILD) begin
      write_register(REG_SETPOINT, $urandom);
      write_register(REG_GAIN_P, $urandom);
      write_register(REG_GAIN_I, $urandom);
      write_register(REG_GAIN_D, $urandom);
      write_register(REG_GAIN_FF, $urandom);
      zone = $urandom;
    end else begin
      write_register(REG_SETPOINT, rand_between(-262144000, 262144000));
      write_register(REG_GAIN_P, rand_between(-4096, 4096));
      write_register(REG_GAIN_I, rand_between(-65536, 65536));
      write_register(REG_GAIN_D, rand_between(-64, 64));
      write_register(REG_GAIN_FF, rand_between(-4096, 4096));
      // bit 31 is outside the zone register and must be dropped
      zone = (style == TUNE_TIGHT) ? $urandom_range(0, 1 << 24) : $urandom_range(0, 1 << 30);
      zone[31] = 1'($urandom_range(0, 1));
    end
    write_register(REG_ZONE, zone);
    write_register(REG_INVERT, $urandom);
  endtask

  // Mostly smooth wheel motion, some jumps and arbitrary intervals
  task automatic send_random_sample();
    int pick;
    logic signed [SAMPLE_W-1:0] count;
    logic [IVL_W-1:0] ivl;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      count = last_count + SAMPLE_W'(rand_between(-100, 100));
      ivl   = IVL_W'($urandom_range(5, 60));
    end else if (pick < 85) begin
      count = SAMPLE_W'($urandom);
      ivl   = IVL_W'($urandom_range(1, 200));
    end else begin
      count = SAMPLE_W'($urandom);
      ivl   = IVL_W'($urandom);
    end
    send_sample(count, ivl);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_reset_tuning();
    send_sample(0, 20);
    send_sample(100, 20);
  endtask

  task automatic test_sample_extremes();
    send_sample(16'sh7FFF, 1);
    send_sample(-16'sh8000, 1);
    send_sample(5, 0);          // zero interval counts as one
    send_sample(-5, 16'hFFFF);
    send_sample(0, 16'h8000);
  endtask

  task automatic test_inverted_sample();
    write_register(REG_INVERT, 1);
    send_sample(-16'sh8000, 20);  // negation saturates
    send_sample(16'sh7FFF, 20);
    send_sample(0, 20);
  endtask

  task automatic test_register_extremes();
    // overflowing terms and derivative in the positive direction
    write_register(REG_SETPOINT, 32'h7FFF_FFFF);
    write_register(REG_GAIN_P, 32'h7FFF_FFFF);
    write_register(REG_GAIN_I, 32'h8000_0000);
    write_register(REG_GAIN_D, 32'h7FFF_FFFF);
    write_register(REG_GAIN_FF, 32'h8000_0000);
    write_register(REG_ZONE, 32'hFFFF_FFFF);
    write_register(REG_INVERT, 0);
    send_sample(0, 1);
    send_sample(16'sh7FFF, 1);
    send_sample(-16'sh8000, 1);
    send_sample(0, 16'hFFFF);
    // opposite signs, integral always cleared
    write_register(REG_SETPOINT, 32'h8000_0000);
    write_register(REG_GAIN_P, 32'h8000_0000);
    write_register(REG_GAIN_I, 32'h7FFF_FFFF);
    write_register(REG_GAIN_D, 32'h8000_0000);
    write_register(REG_GAIN_FF, 32'h7FFF_FFFF);
    write_register(REG_ZONE, 0);
    send_sample(100, 0);
    send_sample(-100, 3);
  endtask

  task automatic test_unmapped_register();
    write_register(REG_UNMAPPED, 32'h1234_5678);
    send_sample(40, 20);
  endtask

  // Output held off long enough that the block fills and stalls its input
  task automatic test_backpressure();
    int n;
    set_idling(IDLE_NONE);
    retune(TUNE_GENTLE);
    wait_results();
    hold_off_left = 600;
    for (n = 0; n < 10; n++) send_random_sample();
    wait_results();
    for (n = 0; n < 10; n++) send_random_sample();
  endtask

  task automatic test_random_sweep();
    int phase;
    for (phase = 0; phase < 12; phase++) begin
      set_idling(phase % 4);
      retune(phase / 4);
      repeat (125) send_random_sample();
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = REG_SETPOINT;
    cfg_wdata_i     = '0;
    in_valid_i      = 1'b0;
    encoder_count_i = '0;
    interval_ms_i   = '0;
    mismatches      = 0;
    quiet_cycles    = 0;
    hold_off_left   = 0;
    last_count      = '0;
    set_idling(IDLE_NONE);
    reset_prediction();

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_tuning();
    test_sample_extremes();
    test_inverted_sample();
    test_register_extremes();
    test_unmapped_register();
    test_backpressure();
    test_random_sweep();

    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

[files.f]
src/vpid_pkg.sv
src/vpid_regs.sv
src/vpid_div.sv
src/vpid_core.sv
src/velocity_pid_controller.sv
src/vpid_checker.sv
test/testbench.sv
